@@ src/framed_packet_parser_core_assert.svh @@
// Assertion macros shared by the parser modules.
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef FRAMED_PACKET_PARSER_CORE_ASSERT_SVH
`define FRAMED_PACKET_PARSER_CORE_ASSERT_SVH

// Checks that a property holds at every clock edge outside reset.
`define FPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never occurs outside reset.
`define FPP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ src/fpp_pkg.sv @@
`default_nettype none
package fpp_pkg;

  // Default payload capacity of one frame.
  localparam int MAX_PAYLOAD_DEF = 32;

  // Width of a payload length inside a frame descriptor; covers capacities up to 127.
  localparam int PLEN_W = 7;

  // Configuration port widths.
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // Payload byte value that marks a harvestable frame.
  localparam logic [7:0] HARVEST_YES = 8'h01;

  // Parser phases of the front part.
  typedef enum logic [2:0] {
    PH_SOF,
    PH_LEN,
    PH_FUNC,
    PH_PAY,
    PH_SUM,
    PH_EOF
  } phase_t;

  // Decoded frame kinds.
  typedef enum logic [1:0] {
    KIND_GENERIC,
    KIND_COORD,
    KIND_HARVEST,
    KIND_COUNT
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MARKERS_A,
    REG_MARKERS_B,
    REG_MARKERS_C,
    REG_COORD_CODE,
    REG_HARVEST_CODE,
    REG_COUNT_CODE,
    REG_COORD_BIG_ENDIAN
  } reg_index_t;

  // Back part states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SHOW
  } back_state_t;

  // Configuration seen by the front part.
  typedef struct packed {
    logic [15:0] markers_a;
    logic [15:0] markers_b;
    logic [15:0] markers_c;
    logic [7:0]  coord_code;
    logic [7:0]  harvest_code;
    logic [7:0]  count_code;
    logic        coord_big_endian;
  } cfg_t;

  // One completed frame, handed from the front part to the back part.
  typedef struct packed {
    logic [7:0]        start;
    logic [7:0]        code;
    logic [PLEN_W-1:0] plen;
    kind_t             kind;
    logic [15:0]       cx;
    logic [15:0]       cy;
    logic              hv;
    logic [7:0]        rp;
    logic [7:0]        ur;
  } desc_t;

endpackage
`default_nettype wire

@@ src/fpp_ram.sv @@
`default_nettype none
module fpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/fpp_desc_queue.sv @@
`default_nettype none
module fpp_desc_queue
  import fpp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t desc_in,
  output logic       full,
  input  wire logic  pop,
  output desc_t      desc_out,
  output logic       empty
);

  `include "framed_packet_parser_core_assert.svh"

  desc_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign desc_out = entries[rd_ptr];

  // Two-entry descriptor queue; one entry per payload bank.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= desc_in;
        wr_ptr          <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `FPP_NEVER(a_no_overflow, push && full, "descriptor pushed into a full queue")
  `FPP_NEVER(a_no_underflow, pop && empty, "descriptor popped from an empty queue")
  `FPP_ASSERT(a_count_up, (push && !pop) |=> (count == $past(count) + 2'd1),
              "queue count did not follow a push")

endmodule
`default_nettype wire

@@ src/fpp_front.sv @@
`default_nettype none
module fpp_front
  import fpp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  input  wire logic [7:0] rx_byte,
  output logic            ram_we,
  output logic [$clog2(MAX_PAYLOAD):0] ram_waddr,
  output logic [7:0]      ram_wdata,
  output logic            q_push,
  output desc_t           q_desc
);

  localparam int IW = $clog2(MAX_PAYLOAD);
  localparam int LW = $clog2(MAX_PAYLOAD + 2);
  localparam logic [7:0] LEN_LIMIT = 8'(MAX_PAYLOAD + 1);

  phase_t          phase, phase_next;
  logic [7:0]      held_start, held_start_next;
  logic [7:0]      expected_end, expected_end_next;
  logic [LW-1:0]   frame_len, frame_len_next;
  logic [7:0]      held_code, held_code_next;
  logic [7:0]      running_sum, running_sum_next;
  logic [IW-1:0]   fill_index, fill_index_next;
  logic            wbank, wbank_next;
  logic [7:0]      first_bytes [4];
  logic            capture;
  logic [LW-1:0]   plen;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SOF;
      held_start   <= 8'd0;
      expected_end <= 8'd0;
      frame_len    <= '0;
      held_code    <= 8'd0;
      running_sum  <= 8'd0;
      fill_index   <= '0;
      wbank        <= 1'b0;
    end else begin
      phase        <= phase_next;
      held_start   <= held_start_next;
      expected_end <= expected_end_next;
      frame_len    <= frame_len_next;
      held_code    <= held_code_next;
      running_sum  <= running_sum_next;
      fill_index   <= fill_index_next;
      wbank        <= wbank_next;
    end
  end

  // The first four payload bytes are kept for decoding at the end marker.
  assign capture = in_valid && (phase == PH_PAY) && (LW'(fill_index) < LW'(4));

  always_ff @(posedge clk) begin
    if (capture) begin
      first_bytes[fill_index[1:0]] <= rx_byte;
    end
  end

  assign plen      = frame_len - LW'(1);
  assign ram_waddr = {wbank, fill_index};
  assign ram_wdata = rx_byte;

  // Parser phase sequencing, one received byte per transfer.
  always_comb begin
    phase_next        = phase;
    held_start_next   = held_start;
    expected_end_next = expected_end;
    frame_len_next    = frame_len;
    held_code_next    = held_code;
    running_sum_next  = running_sum;
    fill_index_next   = fill_index;
    wbank_next        = wbank;
    ram_we            = 1'b0;
    q_push            = 1'b0;
    if (in_valid) begin
      unique case (phase)
        PH_SOF: begin
          // Marker pairs are tried in order a, b, c.
          if (rx_byte == cfg.markers_a[7:0]) begin
            expected_end_next = cfg.markers_a[15:8];
            phase_next        = PH_LEN;
          end else if (rx_byte == cfg.markers_b[7:0]) begin
            expected_end_next = cfg.markers_b[15:8];
            phase_next        = PH_LEN;
          end else if (rx_byte == cfg.markers_c[7:0]) begin
            expected_end_next = cfg.markers_c[15:8];
            phase_next        = PH_LEN;
          end
          held_start_next  = rx_byte;
          running_sum_next = 8'd0;
          fill_index_next  = '0;
        end
        PH_LEN: begin
          frame_len_next   = rx_byte[LW-1:0];
          running_sum_next = running_sum + rx_byte;
          if (rx_byte == 8'd0 || rx_byte > LEN_LIMIT) begin
            phase_next = PH_SOF;
          end else begin
            phase_next = PH_FUNC;
          end
        end
        PH_FUNC: begin
          held_code_next   = rx_byte;
          running_sum_next = running_sum + rx_byte;
          phase_next       = (frame_len > LW'(1)) ? PH_PAY : PH_SUM;
        end
        PH_PAY: begin
          ram_we           = 1'b1;
          fill_index_next  = fill_index + IW'(1);
          running_sum_next = running_sum + rx_byte;
          if (LW'(fill_index) + LW'(1) >= plen) begin
            phase_next = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_next = (rx_byte == running_sum) ? PH_EOF : PH_SOF;
        end
        PH_EOF: begin
          // A matching end marker commits the frame and flips the payload bank.
          if (rx_byte == expected_end) begin
            q_push     = 1'b1;
            wbank_next = ~wbank;
          end
          phase_next = PH_SOF;
        end
        default: begin
          phase_next = PH_SOF;
        end
      endcase
    end
  end

  // Frame decoding; codes are tested in the order coordinate, harvestable, count.
  always_comb begin
    q_desc       = '0;
    q_desc.start = held_start;
    q_desc.code  = held_code;
    q_desc.plen  = PLEN_W'(plen);
    q_desc.kind  = KIND_GENERIC;
    priority if (held_code == cfg.coord_code) begin
      if (plen == LW'(4)) begin
        q_desc.kind = KIND_COORD;
        if (cfg.coord_big_endian) begin
          q_desc.cx = {first_bytes[0], first_bytes[1]};
          q_desc.cy = {first_bytes[2], first_bytes[3]};
        end else begin
          q_desc.cx = {first_bytes[1], first_bytes[0]};
          q_desc.cy = {first_bytes[3], first_bytes[2]};
        end
      end
    end else if (held_code == cfg.harvest_code) begin
      if (plen >= LW'(1)) begin
        q_desc.kind = KIND_HARVEST;
        q_desc.hv   = (first_bytes[0] == HARVEST_YES);
      end
    end else if (held_code == cfg.count_code) begin
      if (plen >= LW'(2)) begin
        q_desc.kind = KIND_COUNT;
        q_desc.rp   = first_bytes[0];
        q_desc.ur   = first_bytes[1];
      end
    end else begin
      // Any other code leaves the frame generic.
      q_desc.kind = KIND_GENERIC;
    end
  end

endmodule
`default_nettype wire

@@ src/fpp_back.sv @@
`default_nettype none
module fpp_back
  import fpp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire desc_t      desc,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            ram_re,
  output logic [$clog2(MAX_PAYLOAD):0] ram_raddr,
  input  wire logic [7:0] ram_rdata,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      frame_start,
  output logic [7:0]      function_code,
  output logic [5:0]      payload_length,
  output logic [4:0]      byte_index,
  output logic [7:0]      payload_byte,
  output logic            last,
  output logic [1:0]      decoded_kind,
  output logic signed [15:0] coord_x,
  output logic signed [15:0] coord_y,
  output logic            harvestable,
  output logic [7:0]      ripe_count,
  output logic [7:0]      unripe_count
);

  localparam int IW = $clog2(MAX_PAYLOAD);

  back_state_t       state, state_next;
  logic [IW-1:0]     k, k_next;
  logic              rbank, rbank_next;
  logic [PLEN_W-1:0] last_k;
  logic              is_last;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      k     <= '0;
      rbank <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      rbank <= rbank_next;
    end
  end

  // An empty payload still gives one result.
  assign last_k    = (desc.plen == '0) ? '0 : desc.plen - PLEN_W'(1);
  assign is_last   = (PLEN_W'(k) == last_k);
  assign ram_raddr = {rbank, k};

  // Read a payload byte, then show it until it is transferred.
  always_comb begin
    state_next = state;
    k_next     = k;
    rbank_next = rbank;
    ram_re     = 1'b0;
    q_pop      = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          k_next     = '0;
          state_next = B_READ;
        end
      end
      B_READ: begin
        ram_re     = 1'b1;
        state_next = B_SHOW;
      end
      B_SHOW: begin
        if (pop) begin
          if (is_last) begin
            q_pop      = 1'b1;
            rbank_next = ~rbank;
            state_next = B_IDLE;
          end else begin
            k_next     = k + IW'(1);
            state_next = B_READ;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Result fields; decoded fields appear only on the final result.
  assign empty          = (state != B_SHOW);
  assign frame_start    = desc.start;
  assign function_code  = desc.code;
  assign payload_length = desc.plen[5:0];
  assign byte_index     = 5'(k);
  assign payload_byte   = (desc.plen == '0) ? 8'd0 : ram_rdata;
  assign last           = is_last;
  assign decoded_kind   = is_last ? desc.kind : KIND_GENERIC;
  assign coord_x        = is_last ? desc.cx : 16'sd0;
  assign coord_y        = is_last ? desc.cy : 16'sd0;
  assign harvestable    = is_last & desc.hv;
  assign ripe_count     = is_last ? desc.rp : 8'd0;
  assign unripe_count   = is_last ? desc.ur : 8'd0;

endmodule
`default_nettype wire

@@ src/framed_packet_parser_core.sv @@
// Input: one byte per cycle unless full; full rises while two completed frames await output.
// A frame is queued at its end marker transfer; its first result follows a payload read.
// Output: each result takes a payload memory read, then presentation until popped.
// A frame with n payload bytes gives max(n, 1) results.
// Reset (rst, synchronous): parser, descriptor queue and output side return to idle,
// configuration registers clear to 0; the payload memory is not cleared.
`default_nettype none
module framed_packet_parser_core
  import fpp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [7:0]             rx_byte,
  input  wire logic                   pop,
  output logic                        empty,
  output logic [7:0]                  frame_start,
  output logic [7:0]                  function_code,
  output logic [5:0]                  payload_length,
  output logic [4:0]                  byte_index,
  output logic [7:0]                  payload_byte,
  output logic                        last,
  output logic [1:0]                  decoded_kind,
  output logic signed [15:0]          coord_x,
  output logic signed [15:0]          coord_y,
  output logic                        harvestable,
  output logic [7:0]                  ripe_count,
  output logic [7:0]                  unripe_count
);

  localparam int IW        = $clog2(MAX_PAYLOAD);
  localparam int RAM_DEPTH = 2 * (1 << IW);

  cfg_t        cfg;
  logic        in_valid;
  logic        ram_we;
  logic [IW:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  logic [IW:0] ram_raddr;
  logic [7:0]  ram_rdata;
  logic        q_push;
  desc_t       q_desc_in;
  logic        q_pop;
  desc_t       q_desc_out;
  logic        q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MARKERS_A:        cfg.markers_a        <= cfg_data;
        REG_MARKERS_B:        cfg.markers_b        <= cfg_data;
        REG_MARKERS_C:        cfg.markers_c        <= cfg_data;
        REG_COORD_CODE:       cfg.coord_code       <= cfg_data[7:0];
        REG_HARVEST_CODE:     cfg.harvest_code     <= cfg_data[7:0];
        REG_COUNT_CODE:       cfg.count_code       <= cfg_data[7:0];
        REG_COORD_BIG_ENDIAN: cfg.coord_big_endian <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // A byte is transferred when push is high and full is low.
  assign in_valid = push & ~full;

  fpp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .rx_byte   (rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .q_push    (q_push),
    .q_desc    (q_desc_in)
  );

  // Two payload banks, one per queued frame.
  fpp_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpp_desc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .desc_in  (q_desc_in),
    .full     (full),
    .pop      (q_pop),
    .desc_out (q_desc_out),
    .empty    (q_empty)
  );

  fpp_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .desc           (q_desc_out),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .pop            (pop),
    .empty          (empty),
    .frame_start    (frame_start),
    .function_code  (function_code),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .payload_byte   (payload_byte),
    .last           (last),
    .decoded_kind   (decoded_kind),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .harvestable    (harvestable),
    .ripe_count     (ripe_count),
    .unripe_count   (unripe_count)
  );

endmodule
`default_nettype wire
